@@ src/scmd_pkg.sv @@
// ----------------------------------------------------------------------------
// scmd_pkg
// Shared types and constants of the scope column min/max decimator.
// ----------------------------------------------------------------------------
package scmd_pkg;

   // Screen geometry
   localparam int COL_FIRST  = 20;
   localparam int COL_SPAN   = 260;
   localparam int ROW_TOP    = 20;
   localparam int ROW_BOTTOM = 220;
   localparam int ROW_RANGE  = ROW_BOTTOM - ROW_TOP;
   localparam int ROW_SCALE  = 100;

   // Configuration
   localparam int SAMPLE_COUNT_W     = 16;
   localparam int VDIV_W             = 14;
   localparam int SAMPLE_MV_W        = 16;
   localparam int VDIV_MAX           = 16383;
   localparam int SAMPLE_COUNT_RESET = 1000;
   localparam int VDIV_RESET         = 500;
   localparam int Y_DIVS_DEFAULT     = 4;

   // Divider quotient bits: covers column offsets below 260 and rows below 256
   localparam int QUO_W = 9;

   typedef enum logic {
      REG_SAMPLE_COUNT = 1'b0,
      REG_VOLTS_PER_DIV = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_COL,
      S_COLW,
      S_ROW,
      S_ROWW,
      S_TRACK,
      S_CLOSE,
      S_FEND,
      S_LAST
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ src/scmd_div.sv @@
// ----------------------------------------------------------------------------
// scmd_div
// Restoring divider, one quotient bit per cycle, shared by column and row.
// Caller guarantees num < den * 2**QW.
// ----------------------------------------------------------------------------
module scmd_div import scmd_pkg::*; #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 18,
   parameter int QW    = QUO_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QW-1:0]    quo,
   output div_stat_type     stat
);

   localparam int SH_W  = DEN_W + QW - 1;
   localparam int CW    = (SH_W > NUM_W) ? SH_W : NUM_W;
   localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]  dsh_ff, dsh_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ge;

   assign ge = CW'(rem_ff) >= CW'(dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsh_in  = {den, {(QW-1){1'b0}}};
         quo_in  = '0;
         cnt_in  = CNT_W'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = NUM_W'(CW'(rem_ff) - CW'(dsh_ff));
         end
         quo_in = {quo_ff[QW-2:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ src/scope_column_minmax_decimator.sv @@
// ----------------------------------------------------------------------------
// scope_column_minmax_decimator
// Folds a frame of millivolt samples into one min/max row span per column.
// ----------------------------------------------------------------------------
// Each sample is taken in S_IDLE, scaled in S_MUL, divided for column and row
// in S_COL/S_COLW and S_ROW/S_ROWW, folded in S_TRACK; spans leave via S_CLOSE
// and, at frame end, S_LAST. A sample is taken only once the last is through;
// a waiting span stalls the next sample only while the output register is full.
// Reset (synchronous, active high): registers back to 1000 samples and
// 500 mV/div, frame state cleared, no column open, output empty.
module scope_column_minmax_decimator import scmd_pkg::*; #(
   parameter int Y_DIVS = Y_DIVS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // sample stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_mv
   input  logic        req_tlast,   // last_sample
   // span stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [8:0] column, [16:9] row_low, [24:17] row_high
   output logic        rsp_tlast,   // frame_end
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // divisor d = volts_per_div * Y_DIVS and row numerator 100*(d - mv)
   localparam int D_MAX     = VDIV_MAX * Y_DIVS;
   localparam int DW_RAW    = $clog2(D_MAX + 1);
   localparam int DW        = (DW_RAW > SAMPLE_MV_W) ? DW_RAW : SAMPLE_MV_W;
   localparam int EW        = DW + 2;
   localparam int RNUM_W    = $clog2(ROW_SCALE * (D_MAX + 32768) + 1);
   localparam int CNUM_W    = $clog2(65535 * COL_SPAN + 1);
   localparam int NUM_W     = (RNUM_W > CNUM_W) ? RNUM_W : CNUM_W;
   localparam int DEN_W     = (DW > SAMPLE_COUNT_W) ? DW : SAMPLE_COUNT_W;
   localparam int OVF_W     = ((DW + 8) > NUM_W) ? (DW + 8) : NUM_W;

   state_type state_ff, state_in;

   // configuration registers
   logic [SAMPLE_COUNT_W-1:0] sc_ff, sc_in;
   logic [VDIV_W-1:0]         vdiv_ff, vdiv_in;

   // frame tracking state
   logic [15:0] idx_ff, idx_in;
   logic [8:0]  col_ff, col_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  high_ff, high_in;
   logic        open_ff, open_in;

   // per-sample working registers
   logic signed [SAMPLE_MV_W-1:0] mv_ff, mv_in;
   logic                          last_ff, last_in;
   logic [NUM_W-1:0]              cnum_ff, cnum_in;
   logic [NUM_W-1:0]              rnum_ff, rnum_in;
   logic                          rneg_ff, rneg_in;
   logic                          cdrop_ff, cdrop_in;
   logic                          csmall_ff, csmall_in;
   logic [8:0]                    x_ff, x_in;
   logic [7:0]                    y_ff, y_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  rsp_col_ff, rsp_col_in;
   logic [7:0]  rsp_low_ff, rsp_low_in;
   logic [7:0]  rsp_high_ff, rsp_high_in;
   logic        rsp_last_ff, rsp_last_in;

   // derived values
   logic [SAMPLE_COUNT_W-1:0] den_c;
   logic [VDIV_W-1:0]         scale_c;
   logic [DW-1:0]             d_c;
   logic signed [EW-1:0]      e_c;
   logic                      x_valid;
   logic                      frame_done;
   logic                      out_free;
   logic                      in_xfer;

   // control strobes
   logic       div_start;
   logic       out_load;
   logic       out_fe;

   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [QUO_W-1:0] div_quo;
   div_stat_type     div_stat;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign den_c   = sc_ff - 1'b1;
   assign scale_c = (vdiv_ff == '0) ? VDIV_W'(1) : vdiv_ff;
   assign d_c     = DW'(32'(scale_c) * 32'(Y_DIVS));
   assign e_c     = $signed({2'b00, d_c}) - EW'(mv_ff);

   // a dropped column only happens for t >= sample_count-1 (x >= 280)
   assign x_valid    = csmall_ff || !cdrop_ff;
   assign frame_done = last_ff ||
                       ((17'(idx_ff) + 17'd1) >= 17'(sc_ff));

   // shared divider: column offset first, then row offset
   assign div_num = (state_ff == S_COL) ? cnum_ff : rnum_ff;
   assign div_den = (state_ff == S_COL) ? DEN_W'(den_c) : DEN_W'(d_c);

   scmd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QW    (QUO_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (in_xfer) state_in = S_MUL;
         S_MUL:   state_in = S_COL;
         S_COL:   state_in = S_COLW;
         S_COLW:  if (div_stat.done) state_in = S_ROW;
         S_ROW:   state_in = S_ROWW;
         S_ROWW:  if (div_stat.done) state_in = S_TRACK;
         S_TRACK: begin
            if (x_valid && open_ff && (x_ff != col_ff)) begin
               state_in = S_CLOSE;
            end else begin
               state_in = S_FEND;
            end
         end
         S_CLOSE: if (out_free) state_in = S_FEND;
         S_FEND: begin
            if (frame_done && open_ff) begin
               state_in = S_LAST;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_LAST:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- outputs / datapath ----------------
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      out_fe     = 1'b0;

      sc_in     = sc_ff;
      vdiv_in   = vdiv_ff;
      idx_in    = idx_ff;
      col_in    = col_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      open_in   = open_ff;
      mv_in     = mv_ff;
      last_in   = last_ff;
      cnum_in   = cnum_ff;
      rnum_in   = rnum_ff;
      rneg_in   = rneg_ff;
      cdrop_in  = cdrop_ff;
      csmall_in = csmall_ff;
      x_in      = x_ff;
      y_in      = y_ff;

      // register writes: user issues only while no sample is in flight; not enforced
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_SAMPLE_COUNT:  sc_in   = csr_wdata[SAMPLE_COUNT_W-1:0];
            REG_VOLTS_PER_DIV: vdiv_in = csr_wdata[VDIV_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (in_xfer) begin
               mv_in   = $signed(req_tdata[SAMPLE_MV_W-1:0]);
               last_in = req_tlast;
            end
         end
         S_MUL: begin
            cnum_in   = NUM_W'(idx_ff) * NUM_W'(COL_SPAN);
            csmall_in = sc_ff < SAMPLE_COUNT_W'(2);
            cdrop_in  = idx_ff >= den_c;
            rneg_in   = e_c[EW-1];
            rnum_in   = NUM_W'(e_c[EW-2:0]) * NUM_W'(ROW_SCALE);
         end
         S_COL: div_start = 1'b1;
         S_COLW: begin
            if (div_stat.done) begin
               x_in = csmall_ff ? 9'(COL_FIRST) : 9'(COL_FIRST) + 9'(div_quo);
            end
         end
         S_ROW: div_start = 1'b1;
         S_ROWW: begin
            if (div_stat.done) begin
               // floor(100*(d-mv)/d) clamped to 0..200, then offset by top row
               if (rneg_ff) begin
                  y_in = 8'(ROW_TOP);
               end else if (OVF_W'(rnum_ff) >= OVF_W'({d_c, 8'h00})) begin
                  y_in = 8'(ROW_BOTTOM);
               end else if (div_quo > QUO_W'(ROW_RANGE)) begin
                  y_in = 8'(ROW_BOTTOM);
               end else begin
                  y_in = 8'(ROW_TOP) + div_quo[7:0];
               end
            end
         end
         S_TRACK: begin
            if (x_valid) begin
               if (!open_ff) begin
                  col_in  = x_ff;
                  low_in  = y_ff;
                  high_in = y_ff;
                  open_in = 1'b1;
               end else if (x_ff == col_ff) begin
                  if (y_ff < low_ff)  low_in  = y_ff;
                  if (y_ff > high_ff) high_in = y_ff;
               end
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               out_load = 1'b1;
               col_in   = x_ff;
               low_in   = y_ff;
               high_in  = y_ff;
               open_in  = 1'b1;
            end
         end
         S_FEND: begin
            if (frame_done) begin
               if (!open_ff) begin
                  idx_in  = '0;
                  col_in  = 9'(COL_FIRST);
                  low_in  = 8'(ROW_BOTTOM);
                  high_in = 8'(ROW_TOP);
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_LAST: begin
            if (out_free) begin
               out_load = 1'b1;
               out_fe   = 1'b1;
               idx_in   = '0;
               col_in   = 9'(COL_FIRST);
               low_in   = 8'(ROW_BOTTOM);
               high_in  = 8'(ROW_TOP);
               open_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // output register: loads the open span, drains on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_col_in   = rsp_col_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = col_ff;
         rsp_low_in   = low_ff;
         rsp_high_in  = high_ff;
         rsp_last_in  = out_fe;
      end
   end

   always_ff @(posedge clock) begin
      mv_ff       <= mv_in;
      last_ff     <= last_in;
      cnum_ff     <= cnum_in;
      rnum_ff     <= rnum_in;
      rneg_ff     <= rneg_in;
      cdrop_ff    <= cdrop_in;
      csmall_ff   <= csmall_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         sc_ff        <= SAMPLE_COUNT_W'(SAMPLE_COUNT_RESET);
         vdiv_ff      <= VDIV_W'(VDIV_RESET);
         idx_ff       <= '0;
         col_ff       <= 9'(COL_FIRST);
         low_ff       <= 8'(ROW_BOTTOM);
         high_ff      <= 8'(ROW_TOP);
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         vdiv_ff      <= vdiv_in;
         idx_ff       <= idx_in;
         col_ff       <= col_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_high_ff, rsp_low_ff, rsp_col_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   // every span sits on screen and is ordered
   a_span_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:0] >= 9'(COL_FIRST)) &&
                     (rsp_tdata[8:0] < 9'(COL_FIRST + COL_SPAN)) &&
                     (rsp_tdata[16:9] <= rsp_tdata[24:17]) &&
                     (rsp_tdata[16:9] >= 8'(ROW_TOP)) &&
                     (rsp_tdata[24:17] <= 8'(ROW_BOTTOM)))
      else $error("span out of range");

   // the shared divider is never restarted mid-run
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // a frame-end span leaves the frame state cleared
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_fe) |=> (idx_ff == '0) && !open_ff)
      else $error("frame state not cleared after frame end");

   // a span is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output span overwritten");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scope column min/max decimator. A short table
// of directed samples and register writes is followed by phases of random
// frames under random settings. Every accepted sample is folded into a local
// copy of the column tracker, and every span that leaves the block is
// compared field by field with the oldest predicted span.
// ----------------------------------------------------------------------------
module tb import scmd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCOPE_Y_DIVS   = Y_DIVS_DEFAULT;
   localparam int COL_LIMIT      = COL_FIRST + COL_SPAN;     // column 280: never drawn
   localparam int ROW_MID        = (ROW_TOP + ROW_BOTTOM) / 2;
   localparam int SETTLE_CYCLES  = 48;    // above the worst per-sample latency
   localparam int HOLD_CYCLES    = 400;   // long sink back-pressure, fills the block
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer or register write
   localparam int RAND_PHASES    = 8;
   localparam int PHASE_ITEMS    = 190;
   localparam int DIR_ROWS       = 32;

   typedef struct packed {
      logic [8:0] column;
      logic [7:0] row_low;
      logic [7:0] row_high;
      logic       frame_end;
   } span_type;

   typedef enum logic { ROW_SAMPLE, ROW_CSR } row_kind_type;

   // how a directed sample is checked: tracker, no span at all, or a typed span
   typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_SPAN } row_check_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type reg_sel;
      logic [15:0]   data;      // sample_mv, or the register value
      logic          last;
      row_check_type chk;
      span_type      span;
   } stim_row_type;

   localparam span_type NO_SPAN = '0;
   localparam logic [15:0] MV_EDGES [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

   // ------------------------------------------------------------------------
   // DUT hookup; every driven input starts at a known value
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] sample_mv
   logic        req_tlast  = 1'b0; // last_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [8:0] column, [16:9] row_low, [24:17] row_high
   logic        rsp_tlast;         // frame_end
   logic        csr_wr_en  = 1'b0;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_wdata  = '0;

   scope_column_minmax_decimator #(.Y_DIVS(SCOPE_Y_DIVS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Column tracker: local copy of settings and frame state
   // ------------------------------------------------------------------------
   logic [15:0] cfg_count = 16'(SAMPLE_COUNT_RESET);
   logic [13:0] cfg_vdiv  = 14'(VDIV_RESET);
   logic [15:0] frm_index = '0;
   logic [8:0]  frm_col   = 9'(COL_FIRST);
   logic [7:0]  frm_low   = 8'(ROW_BOTTOM);
   logic [7:0]  frm_high  = 8'(ROW_TOP);
   logic        frm_open  = 1'b0;

   span_type pending_spans [$];   // predicted spans, oldest first
   int       mismatches = 0;

   // pacing controls for the sender and the sink
   bit    sender_idles = 1'b1;
   logic  sink_idles   = 1'b1;
   logic  hold_request = 1'b0;

   // sample index -> screen column (may land past the last drawn column)
   function automatic int column_of(input logic [15:0] t);
      if (cfg_count < 16'd2) return COL_FIRST;
      return COL_FIRST + (int'(t) * COL_SPAN) / (int'(cfg_count) - 1);
   endfunction

   // millivolts -> screen row, floor division, clamped to the grid
   function automatic int row_of(input logic signed [15:0] mv);
      longint scale, num, rowv;
      scale = longint'((cfg_vdiv == '0) ? 14'd1 : cfg_vdiv) * SCOPE_Y_DIVS;
      num   = ROW_MID * scale - ROW_SCALE * longint'(mv);
      if (num >= 0) rowv = num / scale;
      else          rowv = -((-num + scale - 1) / scale);
      if (rowv < ROW_TOP)    rowv = ROW_TOP;
      if (rowv > ROW_BOTTOM) rowv = ROW_BOTTOM;
      return int'(rowv);
   endfunction

   // Fold one sample into the open column; returns the spans it closes.
   function automatic int fold_sample(input logic [15:0] mv, input logic last,
                                      output span_type made [2]);
      int x, y, n;
      n = 0;
      x = column_of(frm_index);
      y = row_of($signed(mv));
      made[0] = NO_SPAN;
      made[1] = NO_SPAN;
      // dropped columns still count toward the frame length
      if (x < COL_LIMIT) begin
         if (frm_open && x != int'(frm_col)) begin
            made[n] = '{column: frm_col, row_low: frm_low, row_high: frm_high,
                        frame_end: 1'b0};
            n++;
            frm_open = 1'b0;
         end
         if (!frm_open) begin
            frm_col  = 9'(x);
            frm_low  = 8'(y);
            frm_high = 8'(y);
            frm_open = 1'b1;
         end else begin
            if (8'(y) < frm_low)  frm_low  = 8'(y);
            if (8'(y) > frm_high) frm_high = 8'(y);
         end
      end
      if (last || int'(frm_index) + 1 >= int'(cfg_count)) begin
         // frame end: an empty frame closes silently
         if (frm_open) begin
            made[n] = '{column: frm_col, row_low: frm_low, row_high: frm_high,
                        frame_end: 1'b1};
            n++;
         end
         frm_index = '0;
         frm_col   = 9'(COL_FIRST);
         frm_low   = 8'(ROW_BOTTOM);
         frm_high  = 8'(ROW_TOP);
         frm_open  = 1'b0;
      end else begin
         frm_index = frm_index + 16'd1;
      end
      return n;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // Offer one sample until it transfers, then record what it should produce.
   task automatic send_sample(input logic [15:0] mv, input logic last,
                              input row_check_type chk, input span_type typed);
      span_type made [2];
      int       n;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mv;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      n = fold_sample(mv, last, made);
      case (chk)
         CHK_MODEL: begin
            for (int i = 0; i < n; i++) pending_spans.push_back(made[i]);
         end
         CHK_SPAN: pending_spans.push_back(typed);
         default: ;   // no span allowed from this sample
      endcase
   endtask

   // Drain every predicted span, then let an in-flight sample that closes
   // nothing finish its divisions before the block is touched.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write while the block is quiet; a frame may still be open.
   task automatic apply_setting(input csr_index_type sel, input logic [15:0] value);
      settle_block();
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (sel == REG_SAMPLE_COUNT) cfg_count = value;
      else                         cfg_vdiv  = value[13:0];
   endtask

   // ------------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------------
   stim_row_type plan [DIR_ROWS] = '{
      // reset settings, 1000 samples at 500 mV/div: row = floor(120 - mv/20);
      // samples 0..3 fall in column 20, samples 4..5 in column 21
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h0000, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h7FFF, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h8000, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h0001, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'hFFFF, 1'b0, CHK_SPAN,
        '{9'd20, 8'd20, 8'd220, 1'b0}},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h0000, 1'b1, CHK_SPAN,
        '{9'd21, 8'd120, 8'd120, 1'b1}},
      // two-sample frames at 1 mV/div: row = 120 - 25*mv; the second sample
      // maps past the screen, is dropped, yet still ends the frame
      '{ROW_CSR, REG_SAMPLE_COUNT, 16'd2, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_CSR, REG_VOLTS_PER_DIV, 16'd1, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h0001, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'hFFFF, 1'b0, CHK_SPAN,
        '{9'd20, 8'd95, 8'd95, 1'b1}},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'hFFFF, 1'b1, CHK_SPAN,
        '{9'd20, 8'd145, 8'd145, 1'b1}},
      // zero frame count and zero scale: every sample is a frame in column 20,
      // scale behaves as 1 mV/div
      '{ROW_CSR, REG_SAMPLE_COUNT, 16'd0, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_CSR, REG_VOLTS_PER_DIV, 16'd0, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h0004, 1'b0, CHK_SPAN,
        '{9'd20, 8'd20, 8'd20, 1'b1}},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h8000, 1'b1, CHK_SPAN,
        '{9'd20, 8'd220, 8'd220, 1'b1}},
      '{ROW_CSR, REG_SAMPLE_COUNT, 16'd1, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'hFFFC, 1'b0, CHK_SPAN,
        '{9'd20, 8'd220, 8'd220, 1'b1}},
      // ten-sample frame, scale at full range (upper data bits must be masked):
      // each sample opens a new column
      '{ROW_CSR, REG_SAMPLE_COUNT, 16'd10, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_CSR, REG_VOLTS_PER_DIV, 16'hFFFF, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h7FFF, 1'b0, CHK_MODEL, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h8000, 1'b0, CHK_MODEL, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h0000, 1'b0, CHK_MODEL, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h04D2, 1'b0, CHK_MODEL, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'hFB2E, 1'b0, CHK_MODEL, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h0005, 1'b0, CHK_MODEL, NO_SPAN},
      // raising the count mid-frame moves the column back to 21
      '{ROW_CSR, REG_SAMPLE_COUNT, 16'd1000, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h0064, 1'b0, CHK_MODEL, NO_SPAN},
      // lowering it below the index: dropped sample that ends the frame
      '{ROW_CSR, REG_SAMPLE_COUNT, 16'd3, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h00C8, 1'b0, CHK_MODEL, NO_SPAN},
      // largest frame count, frame cut short by the flag
      '{ROW_CSR, REG_SAMPLE_COUNT, 16'hFFFF, 1'b0, CHK_NONE, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'h4000, 1'b0, CHK_MODEL, NO_SPAN},
      '{ROW_SAMPLE, REG_SAMPLE_COUNT, 16'hC000, 1'b1, CHK_MODEL, NO_SPAN}
   };

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed table, random phases, drain
   // ------------------------------------------------------------------------
   initial begin
      logic [15:0] count_val, vdiv_val, mv;
      logic        last, end_by_flag;
      int          sent, cap, frame_len, rng;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CSR) apply_setting(plan[r].reg_sel, plan[r].data);
         else send_sample(plan[r].data, plan[r].last, plan[r].chk, plan[r].span);
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         // last phase runs flat out on both sides; others idle at random
         if (ph == RAND_PHASES - 1) begin
            sender_idles = 1'b0;
            sink_idles  <= 1'b0;
         end else begin
            sender_idles = ($urandom_range(0, 3) != 0);
            sink_idles  <= ($urandom_range(0, 3) != 0);
         end

         case ($urandom_range(0, 7))
            0:       count_val = 16'd2;
            1:       count_val = 16'hFFFF;
            2:       count_val = 16'($urandom_range(0, 1));
            3, 4:    count_val = 16'($urandom_range(3, 40));
            5, 6:    count_val = 16'($urandom_range(41, 1200));
            default: count_val = 16'($urandom);
         endcase
         // short frames during the long hold, so spans back up the block
         if (ph == 1) count_val = 16'($urandom_range(3, 40));
         case ($urandom_range(0, 5))
            0:       vdiv_val = 16'd1;
            1:       vdiv_val = 16'h3FFF;
            2:       vdiv_val = 16'd0;
            default: vdiv_val = 16'($urandom_range(1, 10000));
         endcase
         vdiv_val[15:14] = 2'($urandom);   // unused bits must be ignored
         // a phase boundary may land mid-frame: covers columns moving back
         apply_setting(REG_SAMPLE_COUNT, count_val);
         apply_setting(REG_VOLTS_PER_DIV, vdiv_val);

         // mostly the on-screen voltage range, so rows land between the clamps
         rng = ((cfg_vdiv == '0) ? 1 : int'(cfg_vdiv)) * (SCOPE_Y_DIVS + 1);
         if (rng > 32767) rng = 32767;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            cap = (cfg_count < 16'd2) ? 1 : ((cfg_count > 16'd400) ? 400 : int'(cfg_count));
            frame_len   = ($urandom_range(0, 2) == 0) ? cap : $urandom_range(1, cap);
            end_by_flag = (frame_len < int'(cfg_count)) || ($urandom_range(0, 1) == 1);
            for (int k = 0; k < frame_len && sent < PHASE_ITEMS; k++) begin
               case ($urandom_range(0, 9))
                  0:       mv = 16'($urandom);
                  1:       mv = MV_EDGES[$urandom_range(0, 3)];
                  default: mv = 16'(int'($urandom_range(0, 2 * rng)) - rng);
               endcase
               last = (k == frame_len - 1) && end_by_flag;
               if ($urandom_range(0, 24) == 0) last = ~last;   // broken frames
               // long sink hold-off while samples keep coming
               if (ph == 1 && sent == 40) hold_request <= 1'b1;
               send_sample(mv, last, CHK_MODEL, NO_SPAN);
               sent++;
            end
         end
      end

      settle_block();
      if (mismatches == 0 && pending_spans.size() == 0) begin
         $display("** scope_column_minmax_decimator: PASSED **");
      end else begin
         $display("** scope_column_minmax_decimator: FAILED **");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sink pacing: random stall bursts, plus one long hold on request
   // ------------------------------------------------------------------------
   int stall_left = 0;
   int hold_left  = 0;
   bit hold_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (sink_idles && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);   // start a stall burst
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Span checker
   // ------------------------------------------------------------------------
   function automatic void log_mismatch(input string what, input span_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $write("%0t ns: %s: want col %0d rows %0d..%0d end %0b,", $realtime, what,
                want.column, want.row_low, want.row_high, want.frame_end);
         $display(" got col %0d rows %0d..%0d end %0b pad %0h", rsp_tdata[8:0],
                  rsp_tdata[16:9], rsp_tdata[24:17], rsp_tlast, rsp_tdata[31:25]);
      end
   endfunction

   always @(posedge clock) begin : span_check
      span_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{column: rsp_tdata[8:0], row_low: rsp_tdata[16:9],
                 row_high: rsp_tdata[24:17], frame_end: rsp_tlast};
         if (pending_spans.size() == 0) begin
            log_mismatch("span with none predicted", NO_SPAN);
         end else begin
            want = pending_spans.pop_front();
            if (got !== want || rsp_tdata[31:25] !== '0)
               log_mismatch("span mismatch", want);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: any transfer or register write counts as progress
   // ------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** scope_column_minmax_decimator: FAILED **");
         $finish;
      end
   end

endmodule
